>>> rtl/crc16fr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fr_pkg
// Shared constants, types and the CRC-16 byte step for the frame receiver.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

  localparam int PAYLOAD_BYTES = 48;
  localparam int FRAME_LEN     = PAYLOAD_BYTES + 5;
  localparam int POS_W         = 6;
  localparam int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  localparam logic [POS_W-1:0] POS_HEAD  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_PAY0  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_CRCLO = POS_W'(2 + PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_CRCHI = POS_W'(3 + PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_TAIL  = POS_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PAYLOAD_BYTES - 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8005;

  localparam logic [1:0] ST_GOOD  = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;
  localparam logic [1:0] ST_CRC   = 2'd2;

  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  typedef struct packed {
    logic take_byte;
    logic take_gap;
    logic start_drain;
    logic load_err;
    logic rd_en;
    logic next_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic tail;
    logic good;
    logic last;
  } dp_stat_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/crc16_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Collects fixed frames of serial bytes, checks head, tail and CRC-16, and
// reports status or the payload of a good frame.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    func, rx_byte
//   out      source     out_valid / out_ready  status, payload_byte,
//                                              byte_index, last
//   apb      slave      psel/penable/pready    paddr, pwdata, prdata
//
// Byte and gap items are taken while in_ready is high; the CRC advances a whole byte per cycle while a byte is taken.
// A tail byte blocks input until its results drain: an error result is loaded straight
// into the result registers, each payload result via a registered read of the payload RAM.
// Synchronous reset clears the frame state; no clearing pass is needed.
// A stalled result holds in the output registers until out_ready.
// ----------------------------------------------------------------------------
module crc16_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       payload_byte,
  output logic [5:0]       byte_index,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]             head_value;
  logic [7:0]             tail_value;
  logic                   reg_wr;
  crc16fr_pkg::dp_cmd_t   cmd;
  crc16fr_pkg::dp_stat_t  stat;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_value <= 8'h00;
      tail_value <= 8'h00;
    end else if (reg_wr) begin
      if (paddr[2] == crc16fr_pkg::REG_HEAD) begin
        head_value <= pwdata[7:0];
      end else begin
        tail_value <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == crc16fr_pkg::REG_TAIL) begin
      prdata = {24'h000000, tail_value};
    end else begin
      prdata = {24'h000000, head_value};
    end
  end

  crc16fr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  crc16fr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .rx_byte      (rx_byte),
    .head_value   (head_value),
    .tail_value   (tail_value),
    .status       (status),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

endmodule
`default_nettype wire

>>> rtl/crc16fr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fr_ctrl
// Sequencer: takes bytes, then either shows one error result or drains the
// stored payload one result at a time.
// ----------------------------------------------------------------------------
module crc16fr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 func,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire crc16fr_pkg::dp_stat_t stat,
  output crc16fr_pkg::dp_cmd_t      cmd
);

  localparam logic [1:0] S_IN  = 2'd0;
  localparam logic [1:0] S_RD  = 2'd1;
  localparam logic [1:0] S_OUT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IN);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IN: begin
        if (in_valid) begin
          if (func) begin
            cmd.take_gap = 1'b1;
          end else begin
            cmd.take_byte = 1'b1;
            if (stat.tail) begin
              if (stat.good) begin
                cmd.start_drain = 1'b1;
                state_next      = S_RD;
              end else begin
                cmd.load_err = 1'b1;
                state_next   = S_OUT;
              end
            end
          end
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.last) begin
            state_next = S_IN;
          end else begin
            cmd.next_idx = 1'b1;
            state_next   = S_RD;
          end
        end
      end
      default: begin
        state_next = S_IN;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/crc16fr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc16fr_dp
// Frame position, running CRC, received CRC, payload memory and result
// registers.
// ----------------------------------------------------------------------------
module crc16fr_dp (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire crc16fr_pkg::dp_cmd_t   cmd,
  output crc16fr_pkg::dp_stat_t       stat,
  input  wire logic [7:0]             rx_byte,
  input  wire logic [7:0]             head_value,
  input  wire logic [7:0]             tail_value,
  output logic [1:0]                  status,
  output logic [7:0]                  payload_byte,
  output logic [5:0]                  byte_index,
  output logic                        last
);

  logic [crc16fr_pkg::POS_W-1:0] pos;
  logic [15:0]                   crc;
  logic                          head_ok;
  logic [7:0]                    crc_lo;
  logic [7:0]                    crc_hi;
  logic [7:0]                    mem [crc16fr_pkg::PAYLOAD_BYTES];
  logic [crc16fr_pkg::IDX_W-1:0] rd_idx;
  logic [crc16fr_pkg::IDX_W-1:0] wr_idx;
  logic                          in_payload;
  logic                          frame_ok;

  assign in_payload = (pos >= crc16fr_pkg::POS_PAY0) && (pos < crc16fr_pkg::POS_CRCLO);
  assign wr_idx     = crc16fr_pkg::IDX_W'(pos - crc16fr_pkg::POS_PAY0);
  assign frame_ok   = head_ok && (rx_byte == tail_value);

  assign stat.tail = (pos == crc16fr_pkg::POS_TAIL);
  assign stat.good = frame_ok && ({crc_hi, crc_lo} == crc);
  assign stat.last = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      crc     <= crc16fr_pkg::CRC_INIT;
      head_ok <= 1'b0;
    end else if (cmd.take_gap) begin
      pos     <= '0;
      crc     <= crc16fr_pkg::CRC_INIT;
      head_ok <= 1'b0;
    end else if (cmd.take_byte) begin
      if (stat.tail) begin
        pos     <= '0;
        crc     <= crc16fr_pkg::CRC_INIT;
        head_ok <= 1'b0;
      end else begin
        pos <= pos + 1'b1;
        if (pos == crc16fr_pkg::POS_HEAD) begin
          head_ok <= (rx_byte == head_value);
        end
        if (in_payload) begin
          crc <= crc16fr_pkg::crc_step(crc, rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && (pos == crc16fr_pkg::POS_CRCLO)) begin
      crc_lo <= rx_byte;
    end
    if (cmd.take_byte && (pos == crc16fr_pkg::POS_CRCHI)) begin
      crc_hi <= rx_byte;
    end
  end

  // Payload memory: one write port, one registered read into the result byte.
  always_ff @(posedge clk) begin
    if (cmd.take_byte && in_payload) begin
      mem[wr_idx] <= rx_byte;
    end
    if (cmd.rd_en) begin
      payload_byte <= mem[rd_idx];
      status       <= crc16fr_pkg::ST_GOOD;
      last         <= (rd_idx == crc16fr_pkg::LAST_IDX);
    end else if (cmd.load_err) begin
      payload_byte <= 8'h00;
      status       <= frame_ok ? crc16fr_pkg::ST_CRC : crc16fr_pkg::ST_FRAME;
      last         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.start_drain || cmd.load_err) begin
      rd_idx <= '0;
    end else if (cmd.next_idx) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  assign byte_index = 6'(rd_idx);

`ifndef SYNTHESIS
  a_gap_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.take_gap |=> (pos == '0) && (crc == crc16fr_pkg::CRC_INIT) && !head_ok)
    else $error("gap did not clear the partial frame");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= crc16fr_pkg::POS_TAIL)
    else $error("frame position past the tail byte");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_err |=> last && (payload_byte == 8'h00) && (byte_index == 6'd0)
                     && (status != crc16fr_pkg::ST_GOOD))
    else $error("error result loaded with wrong fields");

  a_tail_restart: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_byte && stat.tail) |=> (pos == '0))
    else $error("tail byte did not restart the frame");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CRC-16 frame receiver. A queue-fed driver sends
// frames, partial frames and gaps. A local frame predictor works out the
// status or payload results of every frame. A monitor checks each result
// against the oldest prediction. Head and tail values are changed over APB
// between phases, and in the first two phases the sender and receiver stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_HEAD    = 3'({crc16fr_pkg::REG_HEAD, 2'b00});
  localparam logic [2:0] ADDR_TAIL    = 3'({crc16fr_pkg::REG_TAIL, 2'b00});
  localparam int         DRAIN_CYCLES = 20;

  typedef struct {
    logic       func;
    logic [7:0] data;
    bit         hold;
  } rx_item_t;

  typedef struct {
    logic [1:0] status;
    logic [7:0] pbyte;
    logic [5:0] idx;
    logic       lst;
  } frame_result_t;

  typedef enum {FK_GOOD, FK_BAD_HEAD, FK_BAD_TAIL, FK_BAD_CRC, FK_BAD_HEAD_CRC} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  payload_byte;
  logic [5:0]  byte_index;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  crc16_frame_receiver u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .payload_byte (payload_byte),
    .byte_index   (byte_index),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #5 clk = ~clk;

  // stimulus and expected results
  rx_item_t      rx_q[$];
  frame_result_t result_q[$];
  int            queued_total = 0;
  int            accepted_total = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            err_count = 0;
  int            results_seen = 0;
  int            frames_good = 0;
  int            frames_bad = 0;
  int            gaps_seen = 0;

  // predictor state
  logic [7:0]  cfg_head = 8'h00;
  logic [7:0]  cfg_tail = 8'h00;
  int          fr_pos = 0;
  logic [15:0] fr_crc = crc16fr_pkg::CRC_INIT;
  logic        fr_head_ok = 1'b0;
  logic [7:0]  fr_crc_lo = 8'h00;
  logic [7:0]  fr_crc_hi = 8'h00;
  logic [7:0]  fr_payload[crc16fr_pkg::PAYLOAD_BYTES];

  // bitwise CRC-16, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ data[k];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ crc16fr_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic frame_restart();
    fr_pos     = 0;
    fr_crc     = crc16fr_pkg::CRC_INIT;
    fr_head_ok = 1'b0;
  endtask

  task automatic predict_frame_step(input logic f, input logic [7:0] b);
    frame_result_t r;
    if (f) begin
      gaps_seen++;
      frame_restart();
      return;
    end
    if (fr_pos == 0) begin
      fr_head_ok = (b == cfg_head);
    end else if (fr_pos >= 2 && fr_pos < 2 + crc16fr_pkg::PAYLOAD_BYTES) begin
      fr_payload[fr_pos-2] = b;
      fr_crc = crc16_byte(fr_crc, b);
    end else if (fr_pos == 2 + crc16fr_pkg::PAYLOAD_BYTES) begin
      fr_crc_lo = b;
    end else if (fr_pos == 3 + crc16fr_pkg::PAYLOAD_BYTES) begin
      fr_crc_hi = b;
    end
    if (fr_pos + 1 < crc16fr_pkg::FRAME_LEN) begin
      fr_pos++;
      return;
    end
    // tail byte: framing errors win over a CRC mismatch
    if (!fr_head_ok || b != cfg_tail) begin
      r = '{crc16fr_pkg::ST_FRAME, 8'h00, 6'd0, 1'b1};
      result_q.push_back(r);
      frames_bad++;
    end else if ({fr_crc_hi, fr_crc_lo} != fr_crc) begin
      r = '{crc16fr_pkg::ST_CRC, 8'h00, 6'd0, 1'b1};
      result_q.push_back(r);
      frames_bad++;
    end else begin
      for (int i = 0; i < crc16fr_pkg::PAYLOAD_BYTES; i++) begin
        r = '{crc16fr_pkg::ST_GOOD, fr_payload[i], 6'(i),
              1'(i == crc16fr_pkg::PAYLOAD_BYTES - 1)};
        result_q.push_back(r);
      end
      frames_good++;
    end
    frame_restart();
  endtask

  // sender: hold the item until accepted, otherwise maybe idle; a held-back item waits for pending results
  always @(posedge clk) begin : sender
    logic     stalled;
    logic     give;
    rx_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      stalled = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        predict_frame_step(func, rx_byte);
        accepted_total++;
      end
      if (!stalled) begin
        give = rx_q.size() != 0;
        if (give && $urandom_range(99) < send_idle_pct) begin
          give = 1'b0;
        end
        if (give && rx_q[0].hold && result_q.size() != 0) begin
          give = 1'b0;
        end
        if (give) begin
          nxt = rx_q.pop_front();
          in_valid <= 1'b1;
          func     <= nxt.func;
          rx_byte  <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    frame_result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, got status %0d byte %0d idx %0d last %0d",
                 $time, status, payload_byte, byte_index, last);
      end else begin
        e = result_q.pop_front();
        check_field("status", e.status, status);
        check_field("payload_byte", e.pbyte, payload_byte);
        check_field("byte_index", e.idx, byte_index);
        check_field("last", e.lst, last);
      end
    end
  end

  task automatic put_item(input logic f, input logic [7:0] data, input bit hold);
    rx_item_t it;
    it = '{f, data, hold};
    rx_q.push_back(it);
    queued_total++;
  endtask

  task automatic queue_frame(input frame_kind_t kind, input bit hold, input bit extremes);
    logic [7:0]  pay[crc16fr_pkg::PAYLOAD_BYTES];
    logic [15:0] c;
    logic [7:0]  hd;
    logic [7:0]  tl;
    c = crc16fr_pkg::CRC_INIT;
    for (int i = 0; i < crc16fr_pkg::PAYLOAD_BYTES; i++) begin
      pay[i] = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
      c = crc16_byte(c, pay[i]);
    end
    hd = cfg_head;
    tl = cfg_tail;
    if (kind == FK_BAD_HEAD || kind == FK_BAD_HEAD_CRC) begin
      hd = cfg_head ^ 8'($urandom_range(1, 255));
    end
    if (kind == FK_BAD_TAIL) begin
      tl = cfg_tail ^ 8'($urandom_range(1, 255));
    end
    if (kind == FK_BAD_CRC || kind == FK_BAD_HEAD_CRC) begin
      c = c ^ 16'($urandom_range(1, 65535));
    end
    put_item(1'b0, hd, hold);
    put_item(1'b0, 8'($urandom_range(255)), 1'b0);
    for (int i = 0; i < crc16fr_pkg::PAYLOAD_BYTES; i++) begin
      put_item(1'b0, pay[i], 1'b0);
    end
    put_item(1'b0, c[7:0], 1'b0);
    put_item(1'b0, c[15:8], 1'b0);
    put_item(1'b0, tl, 1'b0);
  endtask

  // drop a frame after n of its bytes
  task automatic queue_partial(input int n);
    put_item(1'b0, cfg_head, 1'b0);
    for (int i = 1; i < n; i++) begin
      put_item(1'b0, 8'($urandom_range(255)), 1'b0);
    end
    put_item(1'b1, 8'($urandom_range(255)), 1'b0);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_HEAD) begin
      cfg_head = value;
    end else begin
      cfg_tail = value;
    end
  endtask

  task automatic wait_drained();
    while (accepted_total != queued_total || result_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_idling(15, 61);
    reg_write(ADDR_HEAD, 8'h00);
    reg_write(ADDR_TAIL, 8'h00);

    // gaps, a short dropped frame, a good frame, then a frame held back
    // until the good frame's payload has drained
    put_item(1'b1, 8'h00, 1'b0);
    put_item(1'b1, 8'hFF, 1'b0);
    queue_partial(2);
    queue_frame(FK_GOOD, 1'b0, 1'b1);
    queue_frame(FK_BAD_HEAD_CRC, 1'b1, 1'b1);
    wait_drained();

    set_idling(61, 15);
    reg_write(ADDR_HEAD, 8'hFF);
    reg_write(ADDR_TAIL, 8'($urandom_range(255)));
    queue_frame(FK_BAD_TAIL, 1'b0, 1'b0);
    queue_partial($urandom_range(3, 10));
    queue_frame(FK_BAD_CRC, 1'b0, 1'b0);
    wait_drained();

    set_idling(0, 0);
    reg_write(ADDR_HEAD, 8'($urandom_range(255)));
    reg_write(ADDR_TAIL, 8'hFF);
    queue_frame(FK_GOOD, 1'b0, 1'b0);
    wait_drained();

    $display("tb_top: %0d items sent over 3 head/tail settings, %0d gaps",
             accepted_total, gaps_seen);
    $display("tb_top: %0d good frames, %0d rejected frames, %0d results checked",
             frames_good, frames_bad, results_seen);
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timeout, %0d results still expected", $time, result_q.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/crc16fr_pkg.sv
rtl/crc16fr_ctrl.sv
rtl/crc16fr_dp.sv
rtl/crc16_frame_receiver.sv
tb/sv/tb_top.sv
